### rtl/ddm_pkg.sv
// shared constants, types and control structs of the decimal digit multiplier
`timescale 1ns / 1ps

package ddm_pkg;

   localparam int NUM_DIGITS = 16;
   localparam int DIGIT_W    = 4;
   localparam int DIG_AW     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
   localparam int COL_DEPTH  = 2 * NUM_DIGITS;
   localparam int COL_AW     = $clog2(COL_DEPTH);
   // column sum plus incoming carry stays below 250 per digit pair
   localparam int ACC_W      = $clog2(NUM_DIGITS * 250 + 1);
   // divide by ten as multiply by ceil(2^15 / 10) and shift
   localparam int RECIP      = 3277;
   localparam int RECIP_W    = 12;
   localparam int RECIP_SH   = 15;
   localparam int TEN        = 10;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [DIG_AW-1:0]  dig_addr_type;
   typedef logic [COL_AW-1:0]  col_addr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ACC_W-1:0]   acc_type;

   typedef struct packed {
      logic          dig_we;
      dig_addr_type  dig_waddr;
      logic          dig_re;
      dig_addr_type  a_raddr;
      dig_addr_type  b_raddr;
      logic          col_we;
      col_addr_type  col_waddr;
      logic          col_re;
      col_addr_type  col_raddr;
   } mem_ctl_type;

   typedef struct packed {
      logic acc_clear;
      logic acc_add;
      logic digit_we;
   } acc_ctl_type;

endpackage

### rtl/ddm_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface ddm_req_if;
   logic                 valid;
   logic                 ready;
   ddm_pkg::digit_type   a_digit;
   ddm_pkg::digit_type   b_digit;
   logic                 last_pair;

   modport source (output valid, output a_digit, output b_digit, output last_pair,
                   input ready);
   modport sink   (input valid, input a_digit, input b_digit, input last_pair,
                   output ready);
endinterface

interface ddm_rsp_if;
   logic                 valid;
   logic                 ready;
   ddm_pkg::digit_type   product_digit;
   logic                 last_digit;
   logic                 overflow;

   modport source (output valid, output product_digit, output last_digit,
                   output overflow, input ready);
   modport sink   (input valid, input product_digit, input last_digit,
                   input overflow, output ready);
endinterface

### rtl/ddm_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ddm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/ddm_acc.sv
// column accumulator and divide-by-ten carry split
`timescale 1ns / 1ps

module ddm_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  ddm_pkg::acc_ctl_type  acc_ctl,
   input  ddm_pkg::digit_type    a_rd,
   input  ddm_pkg::digit_type    b_rd,
   output ddm_pkg::digit_type    col_digit
);

   ddm_pkg::acc_type acc_ff;
   ddm_pkg::acc_type acc_in;
   logic [2*ddm_pkg::DIGIT_W-1:0] prod;
   logic [ddm_pkg::ACC_W+ddm_pkg::RECIP_W-1:0] rec_full;
   ddm_pkg::acc_type quot;
   ddm_pkg::acc_type quot_x10;
   ddm_pkg::acc_type rem;

   assign prod = {{ddm_pkg::DIGIT_W{1'b0}}, a_rd} * {{ddm_pkg::DIGIT_W{1'b0}}, b_rd};

   // exact for every column total this block can hold
   assign rec_full = (ddm_pkg::ACC_W+ddm_pkg::RECIP_W)'(acc_ff)
                   * (ddm_pkg::ACC_W+ddm_pkg::RECIP_W)'(ddm_pkg::RECIP);
   assign quot     = ddm_pkg::acc_type'(rec_full >> ddm_pkg::RECIP_SH);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = acc_ff - quot_x10;
   assign col_digit = ddm_pkg::digit_type'(rem);

   always_comb begin
      acc_in = acc_ff;
      priority if (acc_ctl.acc_clear) begin
         acc_in = '0;
      end else if (acc_ctl.digit_we) begin
         // carry seeds the next column
         acc_in = quot;
      end else if (acc_ctl.acc_add) begin
         acc_in = acc_ff + ddm_pkg::acc_type'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      acc_ctl.digit_we |-> (rem < ddm_pkg::acc_type'(ddm_pkg::TEN)))
      else $error("column remainder not a decimal digit");

endmodule

### rtl/ddm_seq.sv
// sequencer: digit loading, column walk, carry steps and product readout
`timescale 1ns / 1ps

module ddm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_last,
   output logic                  rsp_overflow,
   output ddm_pkg::mem_ctl_type  mem_ctl,
   output ddm_pkg::acc_ctl_type  acc_ctl
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ISSUE  = 6'b000010,
      ST_WAIT   = 6'b000100,
      ST_DIGIT  = 6'b001000,
      ST_OSTART = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   ddm_pkg::cnt_type       cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;
   ddm_pkg::dig_addr_type  km1_ff, km1_in;
   ddm_pkg::col_addr_type  top_ff, top_in;
   ddm_pkg::col_addr_type  p_ff, p_in;
   ddm_pkg::dig_addr_type  a_ff, a_in;
   ddm_pkg::dig_addr_type  b_ff, b_in;
   ddm_pkg::col_addr_type  o_ff, o_in;
   logic                   rdv_ff, rdv_in;

   logic                   cnt_full;
   ddm_pkg::cnt_type       k_new;
   ddm_pkg::dig_addr_type  km1_new;
   ddm_pkg::col_addr_type  np;
   ddm_pkg::col_addr_type  km1_c;
   logic                   term_last;

   assign cnt_full  = (cnt_ff == ddm_pkg::cnt_type'(ddm_pkg::NUM_DIGITS));
   assign k_new     = cnt_full ? cnt_ff : cnt_ff + ddm_pkg::cnt_type'(1);
   assign km1_new   = ddm_pkg::dig_addr_type'(k_new - ddm_pkg::cnt_type'(1));
   assign np        = p_ff + ddm_pkg::col_addr_type'(1);
   assign km1_c     = ddm_pkg::col_addr_type'(km1_ff);
   // a walks toward the most significant stored digit, b toward the least
   assign term_last = (a_ff == '0) || (b_ff == km1_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      km1_in   = km1_ff;
      top_in   = top_ff;
      p_in     = p_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      o_in     = o_ff;
      rdv_in   = 1'b0;

      mem_ctl.dig_we    = 1'b0;
      mem_ctl.dig_waddr = ddm_pkg::dig_addr_type'(cnt_ff);
      mem_ctl.dig_re    = 1'b0;
      mem_ctl.a_raddr   = a_ff;
      mem_ctl.b_raddr   = b_ff;
      mem_ctl.col_we    = 1'b0;
      mem_ctl.col_waddr = p_ff;
      mem_ctl.col_re    = 1'b0;
      mem_ctl.col_raddr = o_ff;

      acc_ctl.acc_clear = 1'b0;
      acc_ctl.acc_add   = rdv_ff;
      acc_ctl.digit_we  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!cnt_full) begin
                  mem_ctl.dig_we = 1'b1;
                  cnt_in = cnt_ff + ddm_pkg::cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_ISSUE;
                  km1_in   = km1_new;
                  top_in   = ddm_pkg::col_addr_type'({km1_new, 1'b1});
                  p_in     = '0;
                  a_in     = km1_new;
                  b_in     = km1_new;
                  acc_ctl.acc_clear = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            mem_ctl.dig_re = 1'b1;
            rdv_in = 1'b1;
            if (term_last) begin
               state_in = ST_WAIT;
            end else begin
               a_in = a_ff - ddm_pkg::dig_addr_type'(1);
               b_in = b_ff + ddm_pkg::dig_addr_type'(1);
            end
         end
         ST_WAIT: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            mem_ctl.col_we   = 1'b1;
            acc_ctl.digit_we = 1'b1;
            if (p_ff == top_ff) begin
               state_in = ST_OSTART;
            end else begin
               p_in = np;
               if (np <= km1_c) begin
                  a_in = km1_ff;
                  b_in = ddm_pkg::dig_addr_type'(km1_c - np);
               end else begin
                  a_in = ddm_pkg::dig_addr_type'((km1_c << 1) - np);
                  b_in = '0;
               end
               // top column has no terms, only the carry
               state_in = (np == top_ff) ? ST_DIGIT : ST_ISSUE;
            end
         end
         ST_OSTART: begin
            mem_ctl.col_re    = 1'b1;
            mem_ctl.col_raddr = top_ff;
            o_in     = top_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (o_ff == '0) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end else begin
                  o_in = o_ff - ddm_pkg::col_addr_type'(1);
                  mem_ctl.col_re    = 1'b1;
                  mem_ctl.col_raddr = o_ff - ddm_pkg::col_addr_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         rdv_ff   <= rdv_in;
      end
      km1_ff <= km1_in;
      top_ff <= top_in;
      p_ff   <= p_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      o_ff   <= o_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign rsp_last     = (o_ff == '0);
   assign rsp_overflow = ovf_ff;

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> ((a_ff <= km1_ff) && (b_ff <= km1_ff)))
      else $error("digit read address beyond stored digits");

   a_top_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIGIT) && (p_ff == top_ff)) |=> (state_ff == ST_OSTART))
      else $error("column walk did not end after top column");

   a_out_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_ready && (o_ff == '0))
      |=> ((state_ff == ST_IDLE) && (cnt_ff == '0) && !ovf_ff))
      else $error("digit count not cleared after final product word");

endmodule

### rtl/decimal_digit_multiplier.sv
// Loading takes one word per cycle; after the last word the columns are walked, with one read
// of both digit rams per term (k digit pairs kept), before the first product digit shows.
// Throughput: the 2k product digits then leave one per cycle while rsp is ready;
// no new number is taken until the last product digit has left.
// Reset clears the sequencer, digit count and overflow flag; the rams need no clearing.
`timescale 1ns / 1ps

module decimal_digit_multiplier (
   input  logic         clock,
   input  logic         reset,
   ddm_req_if.sink      req_ch,
   ddm_rsp_if.source    rsp_ch
);

   ddm_pkg::mem_ctl_type mem_ctl;
   ddm_pkg::acc_ctl_type acc_ctl;
   ddm_pkg::digit_type   a_rd;
   ddm_pkg::digit_type   b_rd;
   ddm_pkg::digit_type   col_digit;

   ddm_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_last     (req_ch.last_pair),
      .req_ready    (req_ch.ready),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_last     (rsp_ch.last_digit),
      .rsp_overflow (rsp_ch.overflow),
      .mem_ctl      (mem_ctl),
      .acc_ctl      (acc_ctl)
   );

   ddm_ram #(
      .WIDTH (ddm_pkg::DIGIT_W),
      .DEPTH (ddm_pkg::NUM_DIGITS)
   ) u_first_ram (
      .clock (clock),
      .we    (mem_ctl.dig_we),
      .waddr (mem_ctl.dig_waddr),
      .wdata (req_ch.a_digit),
      .re    (mem_ctl.dig_re),
      .raddr (mem_ctl.a_raddr),
      .rdata (a_rd)
   );

   ddm_ram #(
      .WIDTH (ddm_pkg::DIGIT_W),
      .DEPTH (ddm_pkg::NUM_DIGITS)
   ) u_second_ram (
      .clock (clock),
      .we    (mem_ctl.dig_we),
      .waddr (mem_ctl.dig_waddr),
      .wdata (req_ch.b_digit),
      .re    (mem_ctl.dig_re),
      .raddr (mem_ctl.b_raddr),
      .rdata (b_rd)
   );

   ddm_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .acc_ctl   (acc_ctl),
      .a_rd      (a_rd),
      .b_rd      (b_rd),
      .col_digit (col_digit)
   );

   // product digits by column, least significant at address zero
   ddm_ram #(
      .WIDTH (ddm_pkg::DIGIT_W),
      .DEPTH (ddm_pkg::COL_DEPTH)
   ) u_col_ram (
      .clock (clock),
      .we    (mem_ctl.col_we),
      .waddr (mem_ctl.col_waddr),
      .wdata (col_digit),
      .re    (mem_ctl.col_re),
      .raddr (mem_ctl.col_raddr),
      .rdata (rsp_ch.product_digit)
   );

endmodule
